/* rtl/assert_macros.svh */
// Assertion helpers used by rpid_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define RPID_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside reset.
`define RPID_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rpid_pkg.sv */
// ----------------------------------------------------------------------------
// rpid_pkg
// Types, constants and register map of the three-axis rate PID.
// ----------------------------------------------------------------------------
package rpid_pkg;

    localparam int NUM_AXES_DEF = 3;

    localparam logic [8:0]  RATE_BIAS = 9'd27;
    localparam logic [15:0] D_NUM     = 16'hFFFF;
    localparam int          I_SHIFT   = 13;
    localparam int          CT_SHIFT  = 11;
    localparam logic signed [33:0] I_LIMIT = 34'sd256 <<< I_SHIFT;

    localparam logic [1:0] AXIS_YAW = 2'd2;

    localparam logic [1:0] MODE_ANGLE   = 2'd1;
    localparam logic [1:0] MODE_HORIZON = 2'd2;

    localparam logic [23:0] RST_RP_GAINS  = 24'd1515048;
    localparam logic [23:0] RST_YAW_GAINS = 24'd11605;
    localparam logic [15:0] RST_STICK     = 16'd0;
    localparam logic [15:0] RST_LEVEL     = 16'd2650;
    localparam logic [9:0]  RST_MAX_INCL  = 10'd500;

    typedef enum logic [2:0] {
        REG_ROLL_GAINS  = 3'd0,
        REG_PITCH_GAINS = 3'd1,
        REG_YAW_GAINS   = 3'd2,
        REG_STICK_RATES = 3'd3,
        REG_LEVEL_GAINS = 3'd4,
        REG_MAX_INCL    = 3'd5,
        REG_TRIM_ROLL   = 3'd6,
        REG_TRIM_PITCH  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [2:0][23:0]   gains;
        logic [15:0]        stick_rates;
        logic [15:0]        level_gains;
        logic [9:0]         max_incl;
        logic signed [9:0]  trim_roll;
        logic signed [9:0]  trim_pitch;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ANG,
        S_TGT,
        S_ERR,
        S_MUL,
        S_INC,
        S_ACC,
        S_SUM,
        S_DMUL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic cap;
        logic st_a;
        logic st_b;
        logic st_c;
        logic st_d;
        logic st_e;
        logic st_f;
        logic st_g;
        logic st_h;
        logic st_out;
    } t_dp_cmd;

    typedef struct packed {
        logic axis_bad;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage

/* rtl/three_axis_rate_pid.sv */
// ----------------------------------------------------------------------------
// three_axis_rate_pid
// Per-axis rate PID with angle/horizon target, windup clamp and three-sample summed D.
// ----------------------------------------------------------------------------
// One transaction at a time: a new input is accepted only in idle, after the last
// result is loaded into the output register. The D path waits on the 16-step
// bit-serial reciprocal divider; an out-of-range axis skips to the output, result zero.
// Output stalls hold the result and hold off the next accept.
// Reset: synchronous; clears per-axis state and loads default gains.
module three_axis_rate_pid #(
    parameter int NUM_AXES = rpid_pkg::NUM_AXES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_axis_index,
    input  logic signed [10:0] i_rc_command,
    input  logic signed [15:0] i_gyro_rate,
    input  logic signed [11:0] i_attitude_angle,
    input  logic signed [10:0] i_gps_correction,
    input  logic [15:0]        i_cycle_time,
    input  logic [1:0]         i_flight_mode,
    input  logic               i_clear_integrator,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_axis_out,
    output logic signed [15:0] o_pid_out
);
    import rpid_pkg::*;

    t_cfg     r_cfg;
    t_dp_cmd  cmd;
    t_dp_sts  sts;
    t_reg_idx reg_sel;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_sel = t_reg_idx'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gains[0]    <= RST_RP_GAINS;
            r_cfg.gains[1]    <= RST_RP_GAINS;
            r_cfg.gains[2]    <= RST_YAW_GAINS;
            r_cfg.stick_rates <= RST_STICK;
            r_cfg.level_gains <= RST_LEVEL;
            r_cfg.max_incl    <= RST_MAX_INCL;
            r_cfg.trim_roll   <= '0;
            r_cfg.trim_pitch  <= '0;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_ROLL_GAINS:  r_cfg.gains[0]    <= pwdata[23:0];
                REG_PITCH_GAINS: r_cfg.gains[1]    <= pwdata[23:0];
                REG_YAW_GAINS:   r_cfg.gains[2]    <= pwdata[23:0];
                REG_STICK_RATES: r_cfg.stick_rates <= pwdata[15:0];
                REG_LEVEL_GAINS: r_cfg.level_gains <= pwdata[15:0];
                REG_MAX_INCL:    r_cfg.max_incl    <= pwdata[9:0];
                REG_TRIM_ROLL:   r_cfg.trim_roll   <= $signed(pwdata[9:0]);
                REG_TRIM_PITCH:  r_cfg.trim_pitch  <= $signed(pwdata[9:0]);
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_ROLL_GAINS:  prdata = {8'd0, r_cfg.gains[0]};
            REG_PITCH_GAINS: prdata = {8'd0, r_cfg.gains[1]};
            REG_YAW_GAINS:   prdata = {8'd0, r_cfg.gains[2]};
            REG_STICK_RATES: prdata = {16'd0, r_cfg.stick_rates};
            REG_LEVEL_GAINS: prdata = {16'd0, r_cfg.level_gains};
            REG_MAX_INCL:    prdata = {22'd0, r_cfg.max_incl};
            REG_TRIM_ROLL:   prdata = {22'd0, r_cfg.trim_roll};
            REG_TRIM_PITCH:  prdata = {22'd0, r_cfg.trim_pitch};
        endcase
    end

    rpid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    rpid_dp #(
        .NUM_AXES (NUM_AXES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_axis_index       (i_axis_index),
        .i_rc_command       (i_rc_command),
        .i_gyro_rate        (i_gyro_rate),
        .i_attitude_angle   (i_attitude_angle),
        .i_gps_correction   (i_gps_correction),
        .i_cycle_time       (i_cycle_time),
        .i_flight_mode      (i_flight_mode),
        .i_clear_integrator (i_clear_integrator),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_axis_out         (o_axis_out),
        .o_pid_out          (o_pid_out)
    );

endmodule

/* rtl/rpid_div.sv */
// ----------------------------------------------------------------------------
// rpid_div
// Restoring divider, one quotient bit per cycle: D_NUM / divisor.
// ----------------------------------------------------------------------------
module rpid_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [11:0] i_divisor,
    output logic [15:0] o_quot,
    output logic        o_done
);
    import rpid_pkg::*;

    logic        r_busy;
    logic [3:0]  r_idx;
    logic [11:0] r_rem;
    logic [11:0] r_dvs;
    logic [15:0] r_quot;
    logic [12:0] trial;
    logic        fits;

    assign trial = {r_rem, D_NUM[r_idx]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_idx == 4'd0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_idx  <= 4'd15;
            r_rem  <= 12'd0;
            r_dvs  <= i_divisor;
            r_quot <= 16'd0;
        end else if (r_busy) begin
            r_idx  <= r_idx - 4'd1;
            r_rem  <= fits ? 12'(trial - {1'b0, r_dvs}) : trial[11:0];
            r_quot <= {r_quot[14:0], fits};
        end
    end

    assign o_quot = r_quot;
    assign o_done = !r_busy;

endmodule

/* rtl/rpid_ctrl.sv */
// ----------------------------------------------------------------------------
// rpid_ctrl
// Sequencer that steps one axis transaction through the datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpid_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rpid_pkg::t_dp_sts i_sts,
    output rpid_pkg::t_dp_cmd o_cmd
);
    import rpid_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_ANG;
                end
            end
            S_ANG: begin
                o_cmd.st_a = 1'b1;
                n_state    = i_sts.axis_bad ? S_OUT : S_TGT;
            end
            S_TGT: begin
                o_cmd.st_b = 1'b1;
                n_state    = S_ERR;
            end
            S_ERR: begin
                o_cmd.st_c = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.st_d = 1'b1;
                n_state    = S_INC;
            end
            S_INC: begin
                o_cmd.st_e = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.st_f = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.st_g = 1'b1;
                n_state    = S_DMUL;
            end
            S_DMUL: begin
                o_cmd.st_h = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.st_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `RPID_ASSERT_IMP(a_out_load_free, o_cmd.st_out, i_sts.out_free, "result loaded into busy output")
    `RPID_ASSERT_IMP(a_acc_div_done, r_state == S_ACC, i_sts.div_done, "divider not done at D stage")
    `RPID_ASSERT_NXT(a_accept_busy, i_valid && o_ready, r_state == S_ANG, "transaction not started")

endmodule

/* rtl/rpid_dp.sv */
// ----------------------------------------------------------------------------
// rpid_dp
// Datapath: target rate, PID terms, per-axis state and output register.
// ----------------------------------------------------------------------------
module rpid_dp #(
    parameter int NUM_AXES = rpid_pkg::NUM_AXES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rpid_pkg::t_cfg      i_cfg,
    input  rpid_pkg::t_dp_cmd   i_cmd,
    output rpid_pkg::t_dp_sts   o_sts,
    input  logic [1:0]          i_axis_index,
    input  logic signed [10:0]  i_rc_command,
    input  logic signed [15:0]  i_gyro_rate,
    input  logic signed [11:0]  i_attitude_angle,
    input  logic signed [10:0]  i_gps_correction,
    input  logic [15:0]         i_cycle_time,
    input  logic [1:0]          i_flight_mode,
    input  logic                i_clear_integrator,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_axis_out,
    output logic signed [15:0]  o_pid_out
);
    import rpid_pkg::*;

    localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    logic [1:0]         r_axis;
    logic signed [10:0] r_rc;
    logic signed [15:0] r_gyro;
    logic signed [11:0] r_att;
    logic signed [10:0] r_gps;
    logic [15:0]        r_ct;
    logic [1:0]         r_mode;
    logic               r_clr;

    logic signed [22:0] r_integ [NUM_AXES];
    logic signed [19:0] r_last  [NUM_AXES];
    logic signed [30:0] r_dp1   [NUM_AXES];
    logic signed [30:0] r_dp2   [NUM_AXES];

    logic signed [13:0] r_ang_err;
    logic signed [19:0] r_stick;
    logic signed [22:0] r_ang_prod;
    logic signed [22:0] r_hor_prod;
    logic signed [19:0] r_err;
    logic signed [27:0] r_p_prod;
    logic signed [35:0] r_i_prod;
    logic signed [20:0] r_draw;
    logic signed [32:0] r_i_inc;
    logic signed [22:0] r_acc;
    logic signed [36:0] r_d_prod;
    logic signed [32:0] r_sum;
    logic signed [40:0] r_d_mul;

    logic               r_out_valid;
    logic [1:0]         r_axis_out;
    logic signed [15:0] r_pid_out;

    logic [AW-1:0]      idx;
    logic               axis_ok;
    logic               is_yaw;
    logic [23:0]        gains;
    logic [7:0]         rate;
    logic signed [12:0] cmd_ang;
    logic signed [12:0] lim;
    logic signed [12:0] cmd_clamp;
    logic signed [9:0]  trim;
    logic signed [13:0] ang_err;
    logic signed [19:0] stick_t;
    logic signed [19:0] target;
    logic [11:0]        div_in;
    logic [15:0]        quot;
    logic               div_done;
    logic signed [24:0] i_scaled;
    logic signed [33:0] acc_sum;
    logic signed [22:0] acc_clamp;
    logic signed [22:0] integ_base;
    logic signed [30:0] delta;
    logic signed [33:0] res;

    assign idx     = r_axis[AW-1:0];
    assign axis_ok = r_axis < 2'(NUM_AXES);
    assign is_yaw  = r_axis == AXIS_YAW;

    always_comb begin
        case (r_axis)
            2'd1:    gains = i_cfg.gains[1];
            2'd2:    gains = i_cfg.gains[2];
            default: gains = i_cfg.gains[0];
        endcase
    end

    assign rate      = is_yaw ? i_cfg.stick_rates[15:8] : i_cfg.stick_rates[7:0];
    assign cmd_ang   = 13'(r_rc) * 13'sd2 + 13'(r_gps);
    assign lim       = $signed({3'b000, i_cfg.max_incl});
    assign cmd_clamp = (cmd_ang > lim) ? lim : ((cmd_ang < -lim) ? -lim : cmd_ang);
    assign trim      = r_axis[0] ? i_cfg.trim_pitch : i_cfg.trim_roll;
    assign ang_err   = 14'(cmd_clamp) - 14'(r_att) + 14'(trim);
    assign div_in    = (r_ct[15:4] == 12'd0) ? 12'd1 : r_ct[15:4];

    always_comb begin
        stick_t = is_yaw ? (r_stick >>> 5) : (r_stick >>> 4);
        if (!is_yaw && r_mode == MODE_ANGLE) begin
            target = 20'(r_ang_prod >>> 4);
        end else if (!is_yaw && r_mode == MODE_HORIZON) begin
            target = stick_t + 20'(r_hor_prod >>> 8);
        end else begin
            target = stick_t;
        end
    end

    assign i_scaled   = 25'(r_i_prod >>> CT_SHIFT);
    assign integ_base = r_clr ? 23'sd0 : r_integ[idx];
    assign acc_sum    = 34'(integ_base) + 34'(r_i_inc);
    assign acc_clamp  = (acc_sum > I_LIMIT) ? 23'(I_LIMIT)
                      : ((acc_sum < -I_LIMIT) ? 23'(-I_LIMIT) : 23'(acc_sum));
    assign delta      = 31'(r_d_prod >>> 6);
    assign res        = 34'(r_p_prod >>> 7) + 34'(r_acc >>> I_SHIFT) + 34'(r_d_mul >>> 8);

    rpid_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.st_a),
        .i_divisor (div_in),
        .o_quot    (quot),
        .o_done    (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_axis <= i_axis_index;
            r_rc   <= i_rc_command;
            r_gyro <= i_gyro_rate;
            r_att  <= i_attitude_angle;
            r_gps  <= i_gps_correction;
            r_ct   <= i_cycle_time;
            r_mode <= i_flight_mode;
            r_clr  <= i_clear_integrator;
        end
        if (i_cmd.st_a) begin
            r_ang_err <= ang_err;
            r_stick   <= $signed({1'b0, 9'({1'b0, rate} + RATE_BIAS)}) * r_rc;
        end
        if (i_cmd.st_b) begin
            r_ang_prod <= r_ang_err * $signed({1'b0, i_cfg.level_gains[7:0]});
            r_hor_prod <= r_ang_err * $signed({1'b0, i_cfg.level_gains[15:8]});
        end
        if (i_cmd.st_c) begin
            r_err <= target - 20'(r_gyro);
        end
        if (i_cmd.st_d) begin
            r_p_prod <= r_err * $signed({1'b0, gains[7:0]});
            r_i_prod <= r_err * $signed({1'b0, r_ct});
            r_draw   <= 21'(r_err) - 21'(r_last[idx]);
        end
        if (i_cmd.st_e) begin
            r_i_inc <= i_scaled * $signed({1'b0, gains[15:8]});
        end
        if (i_cmd.st_f) begin
            r_acc    <= acc_clamp;
            r_d_prod <= r_draw * $signed({1'b0, quot});
        end
        if (i_cmd.st_g) begin
            r_sum <= 33'(r_dp1[idx]) + 33'(r_dp2[idx]) + 33'(delta);
        end
        if (i_cmd.st_h) begin
            r_d_mul <= r_sum * $signed({1'b0, gains[23:16]});
        end
        if (i_cmd.st_out) begin
            r_axis_out <= r_axis;
            r_pid_out  <= axis_ok ? res[15:0] : 16'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_integ[a] <= '0;
                r_last[a]  <= '0;
                r_dp1[a]   <= '0;
                r_dp2[a]   <= '0;
            end
        end else if (axis_ok) begin
            if (i_cmd.st_d) begin
                r_last[idx] <= r_err;
            end
            if (i_cmd.st_f) begin
                r_integ[idx] <= acc_clamp;
            end
            if (i_cmd.st_g) begin
                r_dp1[idx] <= delta;
                r_dp2[idx] <= r_dp1[idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.st_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.axis_bad = !axis_ok;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_out_valid || i_ready;

    assign o_valid    = r_out_valid;
    assign o_axis_out = r_axis_out;
    assign o_pid_out  = r_pid_out;

endmodule
